[rtl/core/i2c_eeprom_byte_master_defines.svh]
// ----------------------------------------------------------------------------
// i2c eeprom byte master assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock outside reset
`define I2CEB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2ceb check failed");

// consequent must hold in the clock after the antecedent
`define I2CEB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2ceb check failed");

`else

`define I2CEB_ASSERT(lbl, prop)
`define I2CEB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/i2ceb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ceb_pkg
// types, phase codes and script decode for the i2c eeprom byte master
// ----------------------------------------------------------------------------
package i2ceb_pkg;

  // bus phases
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_SA   = 4'd1;
  localparam logic [3:0] PH_SB   = 4'd2;
  localparam logic [3:0] PH_SC   = 4'd3;
  localparam logic [3:0] PH_SD   = 4'd4;
  localparam logic [3:0] PH_BLO  = 4'd5;
  localparam logic [3:0] PH_BHI  = 4'd6;
  localparam logic [3:0] PH_PA   = 4'd7;
  localparam logic [3:0] PH_PB   = 4'd8;
  localparam logic [3:0] PH_PC   = 4'd9;

  // script element kinds
  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_SEND  = 2'd1;
  localparam logic [1:0] K_RECV  = 2'd2;
  localparam logic [1:0] K_STOP  = 2'd3;

  // commands
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CTRL_NAK = 2'd1;
  localparam logic [1:0] ST_ADDR_NAK = 2'd2;
  localparam logic [1:0] ST_DATA_NAK = 2'd3;

  // configuration register indexes
  localparam logic CFG_RESET_BYTE  = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam logic [3:0] CTRL_HI   = 4'hA;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [2:0]  byte_step;
    logic [9:0]  wait_count;
    logic [10:0] held_address;
    logic [7:0]  held_data;
    logic [1:0]  held_command;
    logic [1:0]  last_status;
    logic [7:0]  last_read;
  } seq_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } tick_res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [1:0] code;
  } elem_t;

  function automatic elem_t element(logic [1:0] cmd, logic [2:0] step,
                                    logic [10:0] addr, logic [7:0] data,
                                    logic [7:0] rst_byte);
    elem_t      e;
    logic [7:0] ctrl;
    ctrl = {CTRL_HI, addr[10:8], 1'b0};
    e    = '{kind: K_STOP, tx_byte: 8'd0, code: ST_OK};
    unique case (cmd)
      OP_WRITE: begin
        unique case (step)
          3'd0: e.kind = K_START;
          3'd1: e = '{kind: K_SEND, tx_byte: ctrl, code: ST_CTRL_NAK};
          3'd2: e = '{kind: K_SEND, tx_byte: addr[7:0], code: ST_ADDR_NAK};
          3'd3: e = '{kind: K_SEND, tx_byte: data, code: ST_DATA_NAK};
          default: e.kind = K_STOP;
        endcase
      end
      OP_READ: begin
        unique case (step)
          3'd0: e.kind = K_START;
          3'd1: e = '{kind: K_SEND, tx_byte: ctrl, code: ST_CTRL_NAK};
          3'd2: e = '{kind: K_SEND, tx_byte: addr[7:0], code: ST_ADDR_NAK};
          3'd3: e.kind = K_START;
          3'd4: e = '{kind: K_SEND, tx_byte: {ctrl[7:1], 1'b1}, code: ST_CTRL_NAK};
          3'd5: e.kind = K_RECV;
          default: e.kind = K_STOP;
        endcase
      end
      OP_RESET: begin
        unique case (step)
          3'd0: e.kind = K_START;
          3'd1: e = '{kind: K_SEND, tx_byte: rst_byte, code: ST_OK};
          3'd2: e.kind = K_START;
          default: e.kind = K_STOP;
        endcase
      end
      default: e.kind = K_STOP;
    endcase
    return e;
  endfunction

  // move the sequencer onto a script element
  function automatic seq_state_t enter_step(seq_state_t s, logic [2:0] step,
                                            logic [7:0] rst_byte);
    seq_state_t n;
    elem_t      e;
    n           = s;
    n.byte_step = step;
    e = element(s.held_command, step, s.held_address, s.held_data, rst_byte);
    unique case (e.kind)
      K_START: n.phase = PH_SA;
      K_STOP:  n.phase = PH_PA;
      default: begin
        n.phase      = PH_BLO;
        n.bit_count  = 4'd0;
        n.shift_byte = (e.kind == K_SEND) ? e.tx_byte : 8'd0;
      end
    endcase
    return n;
  endfunction

  function automatic logic [2:0] stop_step(logic [1:0] cmd);
    return (cmd == OP_WRITE) ? 3'd4 : ((cmd == OP_READ) ? 3'd6 : 3'd3);
  endfunction

endpackage

[rtl/core/i2ceb_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ceb_step
// next-state and line levels of the bus sequencer for one tick
// ----------------------------------------------------------------------------
module i2ceb_step (
  input  i2ceb_pkg::seq_state_t state_i,
  input  logic [1:0]            op_i,
  input  logic [10:0]           addr_i,
  input  logic [7:0]            data_i,
  input  logic                  sda_i,
  input  logic [7:0]            reset_byte_i,
  input  logic [9:0]            phase_ticks_i,
  output i2ceb_pkg::seq_state_t state_o,
  output i2ceb_pkg::tick_res_t  res_o
);

  i2ceb_pkg::seq_state_t s;
  i2ceb_pkg::elem_t      e;
  logic [9:0]            ticks;
  logic [10:0]           wait_inc;
  logic                  last_tick;
  logic                  scl;
  logic                  sda;
  logic                  busy;
  logic                  done;

  assign ticks = (phase_ticks_i == 10'd0) ? 10'd1 : phase_ticks_i;

  always_comb begin
    s    = state_i;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b0;
    done = 1'b0;

    // a command starts only from idle and drives its first phase right away
    if (s.phase == i2ceb_pkg::PH_IDLE && op_i != i2ceb_pkg::OP_NONE) begin
      s.held_command = op_i;
      s.held_address = addr_i;
      s.held_data    = data_i;
      s.last_status  = i2ceb_pkg::ST_OK;
      s.wait_count   = 10'd0;
      s = i2ceb_pkg::enter_step(s, 3'd0, reset_byte_i);
    end

    e = i2ceb_pkg::element(s.held_command, s.byte_step, s.held_address,
                           s.held_data, reset_byte_i);
    wait_inc  = {1'b0, s.wait_count} + 11'd1;
    last_tick = (wait_inc >= {1'b0, ticks});

    if (s.phase != i2ceb_pkg::PH_IDLE) begin
      busy = 1'b1;
      unique case (s.phase)
        i2ceb_pkg::PH_SA: begin scl = 1'b0; sda = 1'b1; end
        i2ceb_pkg::PH_SB: begin scl = 1'b1; sda = 1'b1; end
        i2ceb_pkg::PH_SC: begin scl = 1'b1; sda = 1'b0; end
        i2ceb_pkg::PH_SD: begin scl = 1'b0; sda = 1'b0; end
        i2ceb_pkg::PH_BLO, i2ceb_pkg::PH_BHI: begin
          scl = (s.phase == i2ceb_pkg::PH_BHI);
          sda = (e.kind == i2ceb_pkg::K_SEND && s.bit_count < i2ceb_pkg::BYTE_BITS)
                ? s.shift_byte[7] : 1'b1;
        end
        i2ceb_pkg::PH_PA: begin scl = 1'b0; sda = 1'b0; end
        i2ceb_pkg::PH_PB: begin scl = 1'b1; sda = 1'b0; end
        default: begin scl = 1'b1; sda = 1'b1; end
      endcase

      if (!last_tick) begin
        s.wait_count = wait_inc[9:0];
      end else begin
        s.wait_count = 10'd0;
        unique case (s.phase)
          i2ceb_pkg::PH_SA:  s.phase = i2ceb_pkg::PH_SB;
          i2ceb_pkg::PH_SB:  s.phase = i2ceb_pkg::PH_SC;
          i2ceb_pkg::PH_SC:  s.phase = i2ceb_pkg::PH_SD;
          i2ceb_pkg::PH_SD:  s = i2ceb_pkg::enter_step(s, s.byte_step + 3'd1, reset_byte_i);
          i2ceb_pkg::PH_BLO: s.phase = i2ceb_pkg::PH_BHI;
          i2ceb_pkg::PH_BHI: begin
            // ninth bit samples the ack on a send, carries our nack on a receive
            if (s.bit_count < i2ceb_pkg::BYTE_BITS) begin
              s.shift_byte = {s.shift_byte[6:0],
                              (e.kind == i2ceb_pkg::K_RECV) ? sda_i : 1'b0};
              s.bit_count  = s.bit_count + 4'd1;
              s.phase      = i2ceb_pkg::PH_BLO;
            end else if (e.kind == i2ceb_pkg::K_SEND && sda_i &&
                         e.code != i2ceb_pkg::ST_OK) begin
              s.last_status = e.code;
              s = i2ceb_pkg::enter_step(s, i2ceb_pkg::stop_step(s.held_command),
                                        reset_byte_i);
            end else begin
              if (e.kind == i2ceb_pkg::K_RECV) begin
                s.last_read = s.shift_byte;
              end
              s = i2ceb_pkg::enter_step(s, s.byte_step + 3'd1, reset_byte_i);
            end
          end
          i2ceb_pkg::PH_PA:  s.phase = i2ceb_pkg::PH_PB;
          i2ceb_pkg::PH_PB:  s.phase = i2ceb_pkg::PH_PC;
          default: begin
            done        = 1'b1;
            s.phase     = i2ceb_pkg::PH_IDLE;
            s.byte_step = 3'd0;
            s.bit_count = 4'd0;
          end
        endcase
      end
    end
  end

  assign state_o = s;
  assign res_o   = '{scl: scl, sda_out: sda, busy_res: busy, done_res: done,
                     status: s.last_status, read_data: s.last_read};

endmodule

[rtl/core/i2c_eeprom_byte_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// tick-driven i2c master for byte write, random read and bus reset on an
// 11-bit-address serial eeprom
// ----------------------------------------------------------------------------
// usage:
//   each input item is one bus tick carrying the sampled sda level and, while
//   the sequencer is idle, an optional command (write, read, reset sequence).
//   every accepted item yields exactly one result item with the scl and sda
//   levels for that tick plus busy, done, status and the last read byte.
//   the result sits in the output register on the clock after its item is
//   taken. throughput is one item per clock while the output is not stalled,
//   set by the single sequencer update between the state and output registers.
//   when the receiver stalls, the output register holds its item and the
//   input channel stalls only while that full register is not being taken.
//   cfg writes (index 0 reset byte, index 1 phase ticks) are taken at once
//   and are meant to happen while no transaction runs.
//   reset leaves the sequencer idle, status and read data zero, the reset
//   byte at 0xff and the phase length at one tick.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_master_defines.svh"

module i2c_eeprom_byte_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [10:0] in_mem_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata
);

  i2ceb_pkg::seq_state_t state_r;
  i2ceb_pkg::seq_state_t state_nxt;
  i2ceb_pkg::tick_res_t  res_nxt;
  i2ceb_pkg::tick_res_t  res_r;
  logic                  out_valid_r;
  logic [7:0]            reset_byte_r;
  logic [9:0]            phase_ticks_r;
  logic                  in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  i2ceb_step u_step (
    .state_i       (state_r),
    .op_i          (in_operation),
    .addr_i        (in_mem_address),
    .data_i        (in_write_data),
    .sda_i         (in_sda_in),
    .reset_byte_i  (reset_byte_r),
    .phase_ticks_i (phase_ticks_r),
    .state_o       (state_nxt),
    .res_o         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_byte_r  <= 8'hFF;
      phase_ticks_r <= 10'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2ceb_pkg::CFG_RESET_BYTE:  reset_byte_r  <= cfg_wdata[7:0];
        i2ceb_pkg::CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        default:                    phase_ticks_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl       = res_r.scl;
  assign out_sda_out   = res_r.sda_out;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_status    = res_r.status;
  assign out_read_data = res_r.read_data;

  // a finishing tick is always a busy tick
  `I2CEB_ASSERT(a_done_busy, !(out_valid_r && res_r.done_res) || res_r.busy_res)

  // an idle sequencer never keeps a script position
  `I2CEB_ASSERT(a_idle_step, state_r.phase != i2ceb_pkg::PH_IDLE || state_r.byte_step == 3'd0)

  // a plain tick while idle leaves the sequencer idle and shows a released bus
  `I2CEB_ASSERT_NEXT(a_idle_tick, in_accept && state_r.phase == i2ceb_pkg::PH_IDLE && in_operation == i2ceb_pkg::OP_NONE, state_r.phase == i2ceb_pkg::PH_IDLE && res_r.scl && res_r.sda_out && !res_r.busy_res)

endmodule
